// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: rtl/spiq_pkg.sv
package spiq_pkg;

    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_DRAINED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [15:0] job_id;
        logic [15:0] pages;
        logic [7:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_job_id;
        logic [15:0] out_pages;
        logic [7:0]  out_priority;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] job_id;
        logic [15:0] pages;
        logic [7:0]  priority_val;
    } t_entry;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

// File: rtl/stable_priority_insert_queue_top.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
// On an insert, every cell of the chain decides in parallel to hold,
// take the new job, or take its upper neighbor's entry.
// A drain shifts the chain once per result and waits while the output stalls; input
// stalls until the last entry is loaded into the output register.
// Synchronous active-low reset clears the fill count, FSM and output valid.
// The output register takes a new result whenever it is empty or being transferred.
module stable_priority_insert_queue_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spiq_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spiq_pkg::t_out_item  o_out_data
);
    import spiq_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    t_cell_ctl  w_ctl;
    t_entry     w_new;
    t_entry     w_entry [DEPTH];
    logic       w_keep  [DEPTH];
    logic       w_out_free;
    logic       w_in_acc;
    logic       w_full;
    logic       w_empty;
    logic       w_one;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == S_DRAIN) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_one      = (r_count == CNT_W'(1));

    assign w_new.job_id       = i_in_data.job_id;
    assign w_new.pages        = i_in_data.pages;
    assign w_new.priority_val = i_in_data.priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic   w_occ;
            t_entry w_prev;
            logic   w_prev_keep;
            t_entry w_next;

            assign w_occ = (r_count > CNT_W'(gi));
            if (gi == 0) begin : g_head
                assign w_prev      = w_new;
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev      = w_entry[gi-1];
                assign w_prev_keep = w_keep[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            spiq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ),
                .i_new       (w_new),
                .i_prev      (w_prev),
                .i_prev_keep (w_prev_keep),
                .i_next      (w_next),
                .o_entry     (w_entry[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_data.mode && !w_empty && !w_one) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_free && w_one) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs, count and cell commands
    always_comb begin
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_ctl.ins   = 1'b0;
        w_ctl.shift = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (!i_in_data.mode) begin
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_out.status = ST_ADDED;
                            w_ctl.ins    = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (w_empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out.status       = ST_DRAINED;
                        n_out.out_job_id   = w_entry[0].job_id;
                        n_out.out_pages    = w_entry[0].pages;
                        n_out.out_priority = w_entry[0].priority_val;
                        n_out.last         = w_one;
                        w_ctl.shift        = 1'b1;
                        n_count            = r_count - CNT_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_DRAINED;
                    n_out.out_job_id   = w_entry[0].job_id;
                    n_out.out_pages    = w_entry[0].pages;
                    n_out.out_priority = w_entry[0].priority_val;
                    n_out.last         = w_one;
                    w_ctl.shift        = 1'b1;
                    n_count            = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/spiq_cell.sv
module spiq_cell (
    input  logic              i_clk,
    input  spiq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occ,
    input  spiq_pkg::t_entry  i_new,
    input  spiq_pkg::t_entry  i_prev,
    input  logic              i_prev_keep,
    input  spiq_pkg::t_entry  i_next,
    output spiq_pkg::t_entry  o_entry,
    output logic              o_keep
);
    import spiq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stay in place when holding an entry of higher or equal priority.
    assign o_keep  = i_occ && (r_entry.priority_val >= i_new.priority_val);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_prev_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/spiq_checker.sv
`include "assert_macros.svh"

module spiq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input spiq_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input spiq_pkg::t_out_item o_out_data
);
    import spiq_pkg::*;

    logic w_out_acc;
    logic w_not_drained;

    assign w_out_acc     = o_out_valid && !i_out_stall;
    assign w_not_drained = (o_out_data.status != ST_DRAINED);

    // Hold a stalled input item.
    `AST_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
              i_in_valid && $stable(i_in_data))

    // Hold a stalled result.
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
              o_out_valid && $stable(o_out_data))

    // Single-result replies always close their item.
    `AST_SAME(a_single_last, i_clk, i_rst_n, o_out_valid && w_not_drained,
              o_out_data.last)

    // Only drained entries carry data.
    `AST_SAME(a_zero_data, i_clk, i_rst_n, o_out_valid && w_not_drained,
              o_out_data.out_job_id == 16'd0 && o_out_data.out_pages == 16'd0 &&
              o_out_data.out_priority == 8'd0)

    // Hold off new input while a drain still has entries to transfer.
    `AST_SAME(a_drain_stall, i_clk, i_rst_n,
              w_out_acc && !w_not_drained && !o_out_data.last, o_in_stall)

endmodule

bind stable_priority_insert_queue_top spiq_checker u_spiq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
